// ----- sv/isotp_rx_pkg.sv -----
// Shared types and constants for the ISO-TP receive reassembler.
// Holds the frame record passed from the decoder to the output stage.
// No dependencies.
`default_nettype none

package isotp_rx_pkg;

  localparam int NUM_LANES = 7;
  localparam int POS_W     = 12;
  localparam int BASE_W    = 20;

  // Configuration register indexes.
  localparam logic REG_OWN_RX_ID     = 1'b0;
  localparam logic REG_RX_BLOCK_SIZE = 1'b1;

  // PCI types from the high nibble of byte 0.
  localparam logic [3:0] PCI_SINGLE      = 4'h0;
  localparam logic [3:0] PCI_FIRST       = 4'h1;
  localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;
  localparam logic [3:0] PCI_FLOW        = 4'h3;

  // Frame status codes.
  localparam logic [2:0] ST_FOREIGN  = 3'd0;
  localparam logic [2:0] ST_SINGLE   = 3'd1;
  localparam logic [2:0] ST_FIRST    = 3'd2;
  localparam logic [2:0] ST_CONSEC   = 3'd3;
  localparam logic [2:0] ST_LAST_CF  = 3'd4;
  localparam logic [2:0] ST_FLOW     = 3'd5;
  localparam logic [2:0] ST_UNKNOWN  = 3'd6;

  localparam logic [3:0] SF_MAX_LEN  = 4'd7;
  localparam logic [2:0] FF_PAYLOAD  = 3'd6;
  localparam logic [15:0] FF_OFFSET  = 16'd6;

  typedef struct packed {
    logic [2:0]             nbytes;
    logic [6:0][7:0]        bytes;
    logic [POS_W-1:0]       start_pos;
    logic [2:0]             status;
    logic                   fc;
    logic [11:0]            msg_len;
    logic [3:0]             peer_bs;
  } frame_rec_t;

endpackage

`default_nettype wire

// ----- sv/isotp_rx_lane.sv -----
// One byte lane of the consecutive-frame counter compare.
// Uses isotp_rx_pkg for widths.
`default_nettype none

module isotp_rx_lane (
  input  wire logic [isotp_rx_pkg::BASE_W-1:0] base,
  input  wire logic [2:0]                      lane_num,
  input  wire logic [11:0]                     length,
  output logic                                 match
);
  import isotp_rx_pkg::*;

  logic [BASE_W-1:0] count;

  // Running byte count of this lane's byte, compared exactly to the length.
  assign count = base + {{(BASE_W-3){1'b0}}, lane_num};
  assign match = (count == {{(BASE_W-12){1'b0}}, length});

endmodule

`default_nettype wire

// ----- sv/isotp_rx_decode.sv -----
// Frame classifier, transport state and lane merge.
// Uses isotp_rx_pkg; lane matches come from the isotp_rx_lane instances.
`default_nettype none

module isotp_rx_decode (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              take,
  input  wire logic [10:0]                       can_id,
  input  wire logic [7:0][7:0]                   data,
  input  wire logic [10:0]                       own_rx_id,
  input  wire logic [3:0]                        rx_block_size,
  input  wire logic [6:0]                        lane_match,
  output logic [isotp_rx_pkg::BASE_W-1:0]        base,
  output logic [11:0]                            length,
  output isotp_rx_pkg::frame_rec_t               rec
);
  import isotp_rx_pkg::*;

  logic [15:0] frame_sequence, frame_sequence_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [11:0] length_latched, length_latched_next;
  logic [3:0]  peer_bs_latched, peer_bs_latched_next;

  logic [3:0]  pci;
  logic [3:0]  sf_len;
  logic [15:0] seq_inc;
  logic [2:0]  first_hit;
  logic        any_hit;

  assign pci    = data[0][7:4];
  assign length = length_latched;

  // Start count of this block's frame: frame_sequence * 7 + byte_offset.
  assign base = {1'b0, frame_sequence, 3'b000} - {4'b0000, frame_sequence}
              + {4'b0000, byte_offset};

  assign sf_len  = (data[0][3:0] > SF_MAX_LEN) ? SF_MAX_LEN : data[0][3:0];
  assign seq_inc = frame_sequence + 16'd1;

  // Priority merge: the lowest lane whose count reaches the length ends the message.
  always_comb begin
    first_hit = 3'd7;
    any_hit   = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (lane_match[i]) begin
        first_hit = 3'(i + 1);
        any_hit   = 1'b1;
      end
    end
  end

  always_comb begin
    frame_sequence_next  = frame_sequence;
    byte_offset_next     = byte_offset;
    length_latched_next  = length_latched;
    peer_bs_latched_next = peer_bs_latched;
    rec.nbytes    = 3'd0;
    rec.bytes     = {data[7], data[6], data[5], data[4], data[3], data[2], data[1]};
    rec.start_pos = '0;
    rec.status    = ST_FOREIGN;
    rec.fc        = 1'b0;
    if (can_id == own_rx_id) begin
      case (pci)
        PCI_SINGLE: begin
          length_latched_next = {8'd0, sf_len};
          rec.nbytes = sf_len[2:0];
          rec.status = ST_SINGLE;
        end
        PCI_FIRST: begin
          length_latched_next = {data[0][3:0], data[1]};
          frame_sequence_next = '0;
          byte_offset_next    = FF_OFFSET;
          rec.bytes  = {8'd0, data[7], data[6], data[5], data[4], data[3], data[2]};
          rec.nbytes = FF_PAYLOAD;
          rec.status = ST_FIRST;
          rec.fc     = 1'b1;
        end
        PCI_CONSECUTIVE: begin
          rec.start_pos = base[POS_W-1:0];
          rec.nbytes    = first_hit;
          if (any_hit) begin
            rec.status = ST_LAST_CF;
          end else begin
            rec.status = ST_CONSEC;
            frame_sequence_next = seq_inc;
            if (rx_block_size != 4'd0 && seq_inc == {12'd0, rx_block_size}) begin
              frame_sequence_next = '0;
              byte_offset_next = byte_offset
                               + {9'd0, rx_block_size, 3'b000} - {12'd0, rx_block_size};
              rec.fc = 1'b1;
            end
          end
        end
        PCI_FLOW: begin
          peer_bs_latched_next = data[1][3:0];
          rec.status = ST_FLOW;
        end
        default: begin
          rec.status = ST_UNKNOWN;
        end
      endcase
    end
    rec.msg_len = length_latched_next;
    rec.peer_bs = peer_bs_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sequence  <= '0;
      byte_offset     <= '0;
      length_latched  <= '0;
      peer_bs_latched <= '0;
    end else if (take) begin
      frame_sequence  <= frame_sequence_next;
      byte_offset     <= byte_offset_next;
      length_latched  <= length_latched_next;
      peer_bs_latched <= peer_bs_latched_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/isotp_rx_emit.sv -----
// Output stage: a pending frame record and the record being emitted,
// one result item per cycle while out_stall is low. Uses isotp_rx_pkg.
`default_nettype none

module isotp_rx_emit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire isotp_rx_pkg::frame_rec_t  in_rec,
  output logic                           in_stall,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           result_kind,
  output logic [11:0]                    byte_position,
  output logic [7:0]                     byte_value,
  output logic [2:0]                     frame_status,
  output logic [11:0]                    message_length,
  output logic                           send_flow_control,
  output logic [3:0]                     peer_block_size,
  output logic                           last_result
);
  import isotp_rx_pkg::*;

  frame_rec_t e_rec, p_rec;
  logic       e_valid, p_valid;
  logic [2:0] idx;
  logic       pop, pop_last, e_free, load_in_e, load_in_p, move;
  logic       is_status;

  assign in_stall  = p_valid;
  assign pop       = e_valid && !out_stall;
  assign pop_last  = pop && (idx == e_rec.nbytes);
  assign e_free    = !e_valid || pop_last;
  assign load_in_e = take && e_free && !p_valid;
  assign load_in_p = take && !load_in_e;
  assign move      = p_valid && e_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      p_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (load_in_e || move) begin
        e_valid <= 1'b1;
        idx     <= '0;
      end else if (pop_last) begin
        e_valid <= 1'b0;
      end else if (pop) begin
        idx <= idx + 3'd1;
      end
      if (move) begin
        p_valid <= 1'b0;
      end else if (load_in_p) begin
        p_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      e_rec <= p_rec;
    end else if (load_in_e) begin
      e_rec <= in_rec;
    end
    if (load_in_p) begin
      p_rec <= in_rec;
    end
  end

  assign is_status = (idx == e_rec.nbytes);

  always_comb begin
    out_valid         = e_valid;
    result_kind       = is_status;
    byte_position     = is_status ? '0 : e_rec.start_pos + {9'd0, idx};
    byte_value        = is_status ? 8'd0 : e_rec.bytes[idx];
    frame_status      = is_status ? e_rec.status : ST_FOREIGN;
    message_length    = e_rec.msg_len;
    send_flow_control = is_status && e_rec.fc;
    peer_block_size   = e_rec.peer_bs;
    last_result       = is_status;
  end

endmodule

`default_nettype wire

// ----- sv/isotp_receive_reassembler.sv -----
// ISO-TP (CAN transport) receive reassembler, top level.
// Depends on isotp_rx_pkg, isotp_rx_lane, isotp_rx_decode and isotp_rx_emit.
//
// Usage: each input item is one received CAN frame (can_id plus eight data
// bytes), accepted when in_valid is high and in_stall is low. For a frame
// with our identifier the block emits one result item per payload byte
// (result_kind 0, with its message position) followed by one status item
// (result_kind 1, last_result 1). Frames for other identifiers, flow-control
// frames and unknown PCI types give a status item only.
// The configuration channel writes own_rx_id (index 0) or rx_block_size
// (index 1) whenever cfg_valid is high; cfg_ready is always high. Write
// registers only while no frame is in flight.
// When the output stage is empty, the first result item of a frame is on the
// outputs the cycle after the frame is accepted. A frame gives one item per
// payload byte, then a status item, one item per cycle while out_stall is
// low; that output register sets the sustained rate. A pending-frame register
// sits in front of it, so a new frame is taken while results still wait.
// Seven lanes compare the running byte count of each consecutive-frame
// byte with the announced length in parallel; a priority merge picks the
// last byte. When out_stall is high the current item holds; once the
// pending register is full, in_stall rises. Reset clears all transport
// state and loads own_rx_id 2016 and rx_block_size 8.
`default_nettype none

module isotp_receive_reassembler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [10:0] can_id,
  input  wire logic [7:0]  data_byte_0,
  input  wire logic [7:0]  data_byte_1,
  input  wire logic [7:0]  data_byte_2,
  input  wire logic [7:0]  data_byte_3,
  input  wire logic [7:0]  data_byte_4,
  input  wire logic [7:0]  data_byte_5,
  input  wire logic [7:0]  data_byte_6,
  input  wire logic [7:0]  data_byte_7,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [11:0]      byte_position,
  output logic [7:0]       byte_value,
  output logic [2:0]       frame_status,
  output logic [11:0]      message_length,
  output logic             send_flow_control,
  output logic [3:0]       peer_block_size,
  output logic             last_result
);
  import isotp_rx_pkg::*;

  logic [10:0]        own_rx_id;
  logic [3:0]         rx_block_size;
  logic               take;
  logic [7:0][7:0]    data;
  logic [BASE_W-1:0]  base;
  logic [11:0]        length;
  logic [6:0]         lane_match;
  frame_rec_t         rec;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;
  assign data      = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                      data_byte_3, data_byte_2, data_byte_1, data_byte_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_rx_id     <= 11'd2016;
      rx_block_size <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_RX_ID:     own_rx_id     <= cfg_data;
        REG_RX_BLOCK_SIZE: rx_block_size <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Lane i checks byte i+1 of a consecutive frame.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    isotp_rx_lane u_lane (
      .base     (base),
      .lane_num (3'(g + 1)),
      .length   (length),
      .match    (lane_match[g])
    );
  end

  isotp_rx_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .can_id        (can_id),
    .data          (data),
    .own_rx_id     (own_rx_id),
    .rx_block_size (rx_block_size),
    .lane_match    (lane_match),
    .base          (base),
    .length        (length),
    .rec           (rec)
  );

  isotp_rx_emit u_emit (
    .clk               (clk),
    .rst               (rst),
    .take              (take),
    .in_rec            (rec),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_kind       (result_kind),
    .byte_position     (byte_position),
    .byte_value        (byte_value),
    .frame_status      (frame_status),
    .message_length    (message_length),
    .send_flow_control (send_flow_control),
    .peer_block_size   (peer_block_size),
    .last_result       (last_result)
  );

endmodule

`default_nettype wire
